// ===== rtl/sfb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared constants for the sprite XOR framebuffer: opcodes, display size,
// request and result packing widths.
// ----------------------------------------------------------------------------
package sfb_pkg;

  localparam int COLUMNS           = 64;
  localparam int DISPLAY_LINES_DEF = 32;

  // opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_DRAW  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // field widths
  localparam int OPCODE_W = 2;
  localparam int POS_X_W  = 8;
  localparam int POS_Y_W  = 8;
  localparam int ROFF_W   = 4;
  localparam int SPRITE_W = 8;
  localparam int SEL_W    = 5;

  // request packing, first field in the low bits
  localparam int OPCODE_LO = 0;
  localparam int POS_X_LO  = OPCODE_LO + OPCODE_W;
  localparam int POS_Y_LO  = POS_X_LO + POS_X_W;
  localparam int ROFF_LO   = POS_Y_LO + POS_Y_W;
  localparam int SPRITE_LO = ROFF_LO + ROFF_W;
  localparam int SEL_LO    = SPRITE_LO + SPRITE_W;
  localparam int IN_BITS   = SEL_LO + SEL_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // result packing
  localparam int OUT_BITS   = 1 + COLUMNS;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

// ===== rtl/sfb_ram.sv =====
// ----------------------------------------------------------------------------
// sfb_ram
// Generic single-write, single-read RAM with a registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module sfb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sprite_xor_framebuffer_top.sv =====
// ----------------------------------------------------------------------------
// sprite_xor_framebuffer_top
// 64-column one-bit display with sprite-row XOR drawing, collision flag,
// whole-screen clear through per-line valid bits, and line readback.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------------
//  s_*      | in        | request: opcode, pos_x, pos_y, row_offset, sprite_byte,
//           |           |          line_select
//  m_*      | out       | result:  collision, line_pixels
//
//  One request per cycle sustained while the output is not stalled. The line
//  memory is read at the accepting edge into stage 1; the read-modify-write
//  result then goes into the result register, which presents it. Back-to-back
//  draws to the same line use a bypass of the previous write. Reset clears the
//  line valid bits, the collision flag and the pipeline valids; the line memory
//  itself needs no clearing pass. A stalled result holds the stage behind it,
//  and s_tready drops only when both stages are full.
//
module sprite_xor_framebuffer_top #(
  parameter int DISPLAY_LINES = sfb_pkg::DISPLAY_LINES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // opcode, pos_x, pos_y, row_offset, sprite_byte, line_select (low bit up)
  input  logic [sfb_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // collision, line_pixels (low bit up)
  output logic [sfb_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int LW     = $clog2(DISPLAY_LINES);
  localparam int CW     = sfb_pkg::COLUMNS;
  // reciprocal scaled by 2^16, rounded up; exact quotient for any 8-bit pos_y
  localparam int YRECIP = (65536 + DISPLAY_LINES - 1) / DISPLAY_LINES;

  // request fields
  logic [sfb_pkg::OPCODE_W-1:0] in_opcode;
  logic [sfb_pkg::POS_X_W-1:0]  in_pos_x;
  logic [sfb_pkg::POS_Y_W-1:0]  in_pos_y;
  logic [sfb_pkg::ROFF_W-1:0]   in_row_offset;
  logic [sfb_pkg::SPRITE_W-1:0] in_sprite_byte;
  logic [sfb_pkg::SEL_W-1:0]    in_line_select;

  assign in_opcode      = s_tdata[sfb_pkg::OPCODE_LO +: sfb_pkg::OPCODE_W];
  assign in_pos_x       = s_tdata[sfb_pkg::POS_X_LO  +: sfb_pkg::POS_X_W];
  assign in_pos_y       = s_tdata[sfb_pkg::POS_Y_LO  +: sfb_pkg::POS_Y_W];
  assign in_row_offset  = s_tdata[sfb_pkg::ROFF_LO   +: sfb_pkg::ROFF_W];
  assign in_sprite_byte = s_tdata[sfb_pkg::SPRITE_LO +: sfb_pkg::SPRITE_W];
  assign in_line_select = s_tdata[sfb_pkg::SEL_LO    +: sfb_pkg::SEL_W];

  // stage 1 registers
  logic                         s1_valid;
  logic [sfb_pkg::OPCODE_W-1:0] s1_opcode;
  logic [5:0]                   s1_x;
  logic [sfb_pkg::SPRITE_W-1:0] s1_sprite;
  logic [LW-1:0]                s1_line;
  logic                         s1_hit;

  // bypass of the write made at the edge that read this stage's line
  logic                         fwd_en;
  logic [LW-1:0]                fwd_line;
  logic [CW-1:0]                fwd_data;

  logic [DISPLAY_LINES-1:0]     line_valid;
  logic                         collision_flag;

  logic                         out_valid;
  logic                         out_collision;
  logic [CW-1:0]                out_pixels;

  logic                         in_accept;
  logic                         s1_advance;

  logic [21:0]                  y_prod;
  logic [5:0]                   y_quot;
  logic [12:0]                  y_qd;
  logic [7:0]                   rem;
  logic [6:0]                   y_sum;
  logic                         y_ok;
  logic                         sel_ok;
  logic [6:0]                   addr_wide;
  logic                         in_hit;

  logic [CW-1:0]                ram_q;
  logic [CW-1:0]                cur;
  logic [CW-1:0]                mask;
  logic [7:0]                   sprite_rev;
  logic                         wr_en;
  logic [CW-1:0]                wr_data;
  logic                         collision_next;

  assign s1_advance = s1_valid && (!out_valid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign in_accept  = s_tvalid && s_tready;

  // pos_y mod DISPLAY_LINES by reciprocal multiplication
  assign y_prod = 22'(in_pos_y) * 22'(YRECIP);
  assign y_quot = y_prod[21:16];
  assign y_qd   = 13'(y_quot) * 13'(DISPLAY_LINES);
  assign rem    = in_pos_y - y_qd[7:0];

  assign y_sum     = rem[6:0] + 7'(in_row_offset);
  assign y_ok      = y_sum < 7'(DISPLAY_LINES);
  assign sel_ok    = {2'b00, in_line_select} < 7'(DISPLAY_LINES);
  assign addr_wide = (in_opcode == sfb_pkg::OP_READ) ? {2'b00, in_line_select} : y_sum;

  always_comb begin
    case (in_opcode)
      sfb_pkg::OP_DRAW: in_hit = y_ok;
      sfb_pkg::OP_READ: in_hit = sel_ok;
      default:          in_hit = 1'b0;
    endcase
  end

  sfb_ram #(
    .WIDTH (CW),
    .DEPTH (DISPLAY_LINES)
  ) u_lines (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_line),
    .wdata (wr_data),
    .re    (in_accept),
    .raddr (addr_wide[LW-1:0]),
    .rdata (ram_q)
  );

  // current line contents, invalid lines read as zero
  always_comb begin
    cur = '0;
    if (s1_hit && line_valid[s1_line]) begin
      cur = (fwd_en && fwd_line == s1_line) ? fwd_data : ram_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      sprite_rev[k] = s1_sprite[7-k];
    end
  end

  // shifting past column 63 drops those pixels
  assign mask    = {{(CW-8){1'b0}}, sprite_rev} << s1_x;
  assign wr_data = cur ^ mask;
  assign wr_en   = s1_advance && s1_hit && (s1_opcode == sfb_pkg::OP_DRAW);

  always_comb begin
    collision_next = collision_flag;
    if (s1_opcode == sfb_pkg::OP_BEGIN) begin
      collision_next = 1'b0;
    end else if (wr_en && ((cur & mask) != '0)) begin
      collision_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      fwd_en         <= 1'b0;
      line_valid     <= '0;
      collision_flag <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
        fwd_en   <= wr_en;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid      <= 1'b1;
        collision_flag <= collision_next;
        if (s1_opcode == sfb_pkg::OP_CLEAR) begin
          line_valid <= '0;
        end else if (wr_en) begin
          line_valid[s1_line] <= 1'b1;
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode <= in_opcode;
      s1_x      <= in_pos_x[5:0];
      s1_sprite <= in_sprite_byte;
      s1_line   <= addr_wide[LW-1:0];
      s1_hit    <= in_hit;
      fwd_line  <= s1_line;
      fwd_data  <= wr_data;
    end
    if (s1_advance) begin
      out_collision <= collision_next;
      out_pixels    <= (s1_opcode == sfb_pkg::OP_READ) ? cur : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(sfb_pkg::OUT_DATA_W - sfb_pkg::OUT_BITS){1'b0}}, out_pixels, out_collision};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sprite XOR framebuffer. A directed table covers
// reset, edge clipping, collisions, clear and readback. A random phase follows,
// mostly well-formed sprites with random content plus reads, clears and fully
// random requests. A shadow copy of the display predicts every result that
// the table does not give. Bursty input and a stalling output run throughout.
// ----------------------------------------------------------------------------
module tb;

  localparam int DISPLAY_LINES = sfb_pkg::DISPLAY_LINES_DEF;
  localparam int RAND_ITEMS    = 1300;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int TAIL_CYCLES   = 8;

  // packed low bit up: opcode, pos_x, pos_y, row_offset, sprite_byte, line_select
  typedef struct packed {
    logic [sfb_pkg::SEL_W-1:0]    line_select;
    logic [sfb_pkg::SPRITE_W-1:0] sprite_byte;
    logic [sfb_pkg::ROFF_W-1:0]   row_offset;
    logic [sfb_pkg::POS_Y_W-1:0]  pos_y;
    logic [sfb_pkg::POS_X_W-1:0]  pos_x;
    logic [sfb_pkg::OPCODE_W-1:0] opcode;
  } request_t;

  typedef struct packed {
    logic                        collision;
    logic [sfb_pkg::COLUMNS-1:0] pixels;
  } result_t;

  typedef struct {
    request_t                    req;
    bit                          typed;
    logic                        collision;
    logic [sfb_pkg::COLUMNS-1:0] pixels;
  } dir_row_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  // opcode, pos_x, pos_y, row_offset, sprite_byte, line_select
  logic [sfb_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [sfb_pkg::OUT_DATA_W-1:0] m_tdata;   // collision, line_pixels

  // shadow display
  logic [sfb_pkg::COLUMNS-1:0] shadow_line [DISPLAY_LINES];
  logic [DISPLAY_LINES-1:0]    shadow_valid;
  logic                        shadow_collide;

  result_t  frame_results [$];
  dir_row_t dir_rows [$];

  int    errors;
  int    checked;
  int    sent;
  int    cycles;
  int    op_count [4];
  int    collide_hits;
  int    burst_left;
  bit    hold_req;
  int    hold_cnt;
  int    rx_cyc;
  result_t got;
  result_t want;

  sprite_xor_framebuffer_top #(
    .DISPLAY_LINES(DISPLAY_LINES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // applies one request to the shadow display and returns the line/flag result
  function automatic result_t frame_update(request_t r);
    result_t                     res;
    int                          x;
    int                          y;
    int                          k;
    logic [sfb_pkg::COLUMNS-1:0] cur;
    logic [sfb_pkg::COLUMNS-1:0] mask;
    res = '0;
    case (r.opcode)
      sfb_pkg::OP_CLEAR: shadow_valid = '0;
      sfb_pkg::OP_BEGIN: shadow_collide = 1'b0;
      sfb_pkg::OP_DRAW: begin
        x = int'(r.pos_x) % sfb_pkg::COLUMNS;
        y = (int'(r.pos_y) % DISPLAY_LINES) + int'(r.row_offset);
        if (y < DISPLAY_LINES) begin
          cur  = shadow_valid[y] ? shadow_line[y] : '0;
          mask = '0;
          // bit 7 is the leftmost pixel, columns past the right edge drop
          for (k = 0; k < 8; k++) begin
            if (x + k < sfb_pkg::COLUMNS && r.sprite_byte[7-k]) mask[x+k] = 1'b1;
          end
          if ((cur & mask) != '0) begin
            shadow_collide = 1'b1;
            collide_hits++;
          end
          shadow_line[y]  = cur ^ mask;
          shadow_valid[y] = 1'b1;
        end
      end
      default: begin
        if (int'(r.line_select) < DISPLAY_LINES && shadow_valid[r.line_select])
          res.pixels = shadow_line[r.line_select];
      end
    endcase
    res.collision = shadow_collide;
    return res;
  endfunction

  function automatic request_t rand_req();
    request_t    r;
    logic [63:0] bits_v;
    bits_v = {$urandom, $urandom};
    r      = bits_v[sfb_pkg::IN_BITS-1:0];
    return r;
  endfunction

  task automatic add_row(input logic [1:0] op, input int x, input int y, input int roff,
                         input int sb, input int sel, input bit typed, input logic col,
                         input logic [sfb_pkg::COLUMNS-1:0] pix);
    dir_row_t row_v;
    row_v.req.opcode      = op;
    row_v.req.pos_x       = x[7:0];
    row_v.req.pos_y       = y[7:0];
    row_v.req.row_offset  = roff[3:0];
    row_v.req.sprite_byte = sb[7:0];
    row_v.req.line_select = sel[4:0];
    row_v.typed           = typed;
    row_v.collision       = col;
    row_v.pixels          = pix;
    dir_rows.push_back(row_v);
  endtask

  // bursts of random length with random gaps; called at a falling edge
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // offers one request, predicts its result on acceptance, returns at a falling edge
  task automatic offer(input request_t r, input bit typed, input logic col,
                       input logic [sfb_pkg::COLUMNS-1:0] pix);
    logic [sfb_pkg::IN_DATA_W-1:0] word;
    result_t                       res;
    pace();
    word                       = '0;
    word[sfb_pkg::IN_BITS-1:0] = r;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    res = frame_update(r);
    if (typed) begin
      res.collision = col;
      res.pixels    = pix;
    end
    frame_results.push_back(res);
    op_count[r.opcode]++;
    sent++;
    @(negedge clk);
  endtask

  task automatic send(input request_t r);
    offer(r, 1'b0, 1'b0, '0);
  endtask

  // receiver: rotating stall patterns plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    hold_cnt = 0;
    rx_cyc   = 0;
    forever begin
      @(negedge clk);
      rx_cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        case ((rx_cyc / 128) % 5)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          3: m_tready <= rx_cyc[0];
          default: m_tready <= (rx_cyc[3:0] >= 4'd5);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.collision = m_tdata[0];
      got.pixels    = m_tdata[sfb_pkg::COLUMNS:1];
      if (frame_results.size() == 0) begin
        $display("%0t: result with nothing expected, collision %0d pixels %h",
                 $time, got.collision, got.pixels);
        errors++;
      end else begin
        want = frame_results.pop_front();
        checked++;
        if (got.collision !== want.collision) begin
          $display("%0t: collision mismatch, expected %0d actual %0d",
                   $time, want.collision, got.collision);
          errors++;
        end
        if (got.pixels !== want.pixels) begin
          $display("%0t: line_pixels mismatch, expected %h actual %h",
                   $time, want.pixels, got.pixels);
          errors++;
        end
      end
    end
  end

  initial begin
    int          i;
    int          kind;
    int          nrows;
    int          first;
    int          line;
    int          stop_at;
    bit          hold_done;
    bit          drain_done;
    logic [31:0] val;
    request_t    r;

    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    hold_req     = 1'b0;
    errors       = 0;
    checked      = 0;
    sent         = 0;
    cycles       = 0;
    collide_hits = 0;
    burst_left   = 0;
    hold_done    = 1'b0;
    drain_done   = 1'b0;
    op_count     = '{default: 0};
    shadow_valid   = '0;
    shadow_collide = 1'b0;
    for (i = 0; i < DISPLAY_LINES; i++) shadow_line[i] = '0;

    //      op                 x    y    roff sb    sel typed col pixels
    add_row(sfb_pkg::OP_READ,  0,   0,   0,   0,    0,  1, 0, '0);
    add_row(sfb_pkg::OP_READ,  255, 255, 15,  255,  31, 1, 0, '0);
    add_row(sfb_pkg::OP_DRAW,  0,   0,   0,   8'hFF, 0, 1, 0, '0);
    add_row(sfb_pkg::OP_READ,  0,   0,   0,   0,    0,  1, 0, 64'hFF);
    add_row(sfb_pkg::OP_DRAW,  0,   0,   0,   8'hFF, 0, 1, 1, '0);
    add_row(sfb_pkg::OP_READ,  0,   0,   0,   0,    0,  1, 1, '0);
    add_row(sfb_pkg::OP_BEGIN, 0,   0,   0,   0,    0,  1, 0, '0);
    // right edge clip at column 60 on the last line
    add_row(sfb_pkg::OP_DRAW,  252, 255, 0,   8'hFF, 0, 1, 0, '0);
    add_row(sfb_pkg::OP_READ,  0,   0,   0,   0,    31, 1, 0, 64'hF000_0000_0000_0000);
    // bottom edge clip
    add_row(sfb_pkg::OP_DRAW,  0,   31,  15,  8'hFF, 0, 1, 0, '0);
    add_row(sfb_pkg::OP_DRAW,  64,  48,  15,  8'h81, 0, 1, 0, '0);
    add_row(sfb_pkg::OP_READ,  0,   0,   0,   0,    31, 0, 0, '0);
    add_row(sfb_pkg::OP_DRAW,  63,  31,  0,   8'h80, 0, 1, 1, '0);
    // clear keeps the flag
    add_row(sfb_pkg::OP_CLEAR, 255, 255, 15,  255,  31, 1, 1, '0);
    add_row(sfb_pkg::OP_READ,  0,   0,   0,   0,    31, 1, 1, '0);
    add_row(sfb_pkg::OP_BEGIN, 255, 255, 15,  255,  31, 1, 0, '0);
    // stale line contents after clear must not collide
    add_row(sfb_pkg::OP_DRAW,  60,  31,  0,   8'hFF, 0, 1, 0, '0);
    add_row(sfb_pkg::OP_READ,  0,   0,   0,   0,    31, 0, 0, '0);
    add_row(sfb_pkg::OP_DRAW,  0,   0,   0,   8'h00, 0, 0, 0, '0);
    add_row(sfb_pkg::OP_DRAW,  1,   1,   15,  8'hAA, 0, 0, 0, '0);
    add_row(sfb_pkg::OP_READ,  0,   0,   0,   0,    16, 0, 0, '0);
    // back-to-back draws into one line
    add_row(sfb_pkg::OP_DRAW,  4,   5,   0,   8'h0F, 0, 0, 0, '0);
    add_row(sfb_pkg::OP_DRAW,  4,   5,   0,   8'h0F, 0, 0, 0, '0);
    add_row(sfb_pkg::OP_READ,  0,   0,   0,   0,    5,  0, 0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[j]) offer(dir_rows[j].req, dir_rows[j].typed,
                                dir_rows[j].collision, dir_rows[j].pixels);

    stop_at = sent + RAND_ITEMS;
    while (sent < stop_at) begin
      if (!hold_done && sent >= stop_at - RAND_ITEMS + 400) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && sent >= stop_at - RAND_ITEMS + 800) begin
        s_tvalid <= 1'b0;
        while (frame_results.size() != 0) @(posedge clk);
        @(negedge clk);
        drain_done = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // a sprite: begin, consecutive rows, then maybe read one of them back
        r        = rand_req();
        r.opcode = sfb_pkg::OP_BEGIN;
        send(r);
        r        = rand_req();
        r.opcode = sfb_pkg::OP_DRAW;
        nrows    = $urandom_range(1, 15);
        first    = $urandom_range(0, 15 - nrows);
        for (i = 0; i < nrows; i++) begin
          val           = first + i;
          r.row_offset  = val[sfb_pkg::ROFF_W-1:0];
          val           = $urandom;
          r.sprite_byte = val[sfb_pkg::SPRITE_W-1:0];
          val           = $urandom;
          r.line_select = val[sfb_pkg::SEL_W-1:0];
          send(r);
        end
        if ($urandom_range(0, 1) == 1) begin
          line = (int'(r.pos_y) % DISPLAY_LINES) + first + $urandom_range(0, nrows - 1);
          r        = rand_req();
          r.opcode = sfb_pkg::OP_READ;
          if (line < DISPLAY_LINES) begin
            val           = line;
            r.line_select = val[sfb_pkg::SEL_W-1:0];
          end
          send(r);
        end
      end else if (kind < 75) begin
        nrows = $urandom_range(1, 4);
        for (i = 0; i < nrows; i++) begin
          r        = rand_req();
          r.opcode = sfb_pkg::OP_READ;
          send(r);
        end
      end else if (kind < 80) begin
        r        = rand_req();
        r.opcode = sfb_pkg::OP_CLEAR;
        send(r);
      end else begin
        send(rand_req());
      end
    end

    s_tvalid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (frame_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, frame_results.size());
      errors++;
    end

    $display("covered %0d requests: %0d clear, %0d begin, %0d draw, %0d read",
             sent, op_count[sfb_pkg::OP_CLEAR], op_count[sfb_pkg::OP_BEGIN],
             op_count[sfb_pkg::OP_DRAW], op_count[sfb_pkg::OP_READ]);
    $display("%0d results checked, %0d draws hit lit pixels, %0d errors",
             checked, collide_hits, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
